>>> rtl/core/assert_macros.svh
// Assertion helpers; both expect clk in scope, SRLS_CHK also rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SRLS_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRLS_CHK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRLS_CHK(lbl, prop, msg)
`define SRLS_CHK_RST(lbl, prop, msg)
`endif
`endif

>>> rtl/core/srls_pkg.sv
package srls_pkg;

  localparam int RESTART_INDEX_BITS = 20;
  localparam int FRAC_BITS          = 16;

  localparam int FIXW = 32 + FRAC_BITS;          // Q32.F word
  localparam int CLW  = 27;                      // conflict limit
  localparam int LLW  = 32;                      // reported learnt limit
  localparam int CCW  = 32;                      // clause_count register
  localparam int OPW  = 2;
  localparam int SPW  = RESTART_INDEX_BITS + 1;  // Luby span 2^k-1
  localparam int EW   = $clog2(RESTART_INDEX_BITS + 1);
  localparam int WCW  = 7 + (1 << EW);           // 100 << e without loss

  // constant divider: one 16-bit digit per step
  localparam int DIGIT_BITS = 16;
  localparam int DIVW       = FIXW + 4;          // room for x*11
  localparam int DIV_STEPS  = (DIVW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DPAD       = DIV_STEPS * DIGIT_BITS;
  localparam int DCW        = $clog2(DIV_STEPS + 1);
  localparam int DRW        = 4;                 // remainder, below 10
  localparam int NUMW       = DRW + DIGIT_BITS;  // {remainder, digit}

  // reciprocals ceil(2^RCP_SHIFT/d); exact floor for any NUMW-bit numerator
  localparam int RCP_SHIFT = 24;
  localparam int RCPW      = 23;
  localparam int PRODW     = NUMW + RCPW;
  localparam logic [RCPW-1:0] RCP_THREE = 23'd5592406;
  localparam logic [RCPW-1:0] RCP_TEN   = 23'd1677722;

  localparam int BASE_LIMIT = 100;
  localparam logic [CLW-1:0]  CL_MAX  = '1;
  localparam logic [FIXW-1:0] FIX_MAX = '1;
  localparam logic [FIXW-1:0] INTERVAL_RESET = FIXW'(BASE_LIMIT) << FRAC_BITS;

  localparam logic [OPW-1:0] OP_START    = 2'd0;
  localparam logic [OPW-1:0] OP_RESTART  = 2'd1;
  localparam logic [OPW-1:0] OP_CONFLICT = 2'd2;
  localparam logic [OPW-1:0] OP_UNUSED   = 2'd3;

  localparam int APB_AW = 3;
  localparam logic [APB_AW-3:0] REG_CLAUSE_COUNT = '0;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_START,
    ACT_DIV,
    ACT_STORE_LL,
    ACT_GROW,
    ACT_REDUCE,
    ACT_SET_CL,
    ACT_DEC,
    ACT_ADJUST
  } act_t;

  typedef enum logic [3:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_RESTART,
    CND_CONFLICT,
    CND_UNUSED,
    CND_DIV_MORE,
    CND_SPAN_LT,
    CND_SPAN_OPEN,
    CND_CD_NZ,
    CND_OUT_HELD
  } cnd_t;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_ENTRY     = 4'd0;
  localparam logic [PC_W-1:0] PC_SEL_CONFL = 4'd1;
  localparam logic [PC_W-1:0] PC_SEL_NONE  = 4'd2;
  localparam logic [PC_W-1:0] PC_START     = 4'd3;
  localparam logic [PC_W-1:0] PC_DIV       = 4'd4;
  localparam logic [PC_W-1:0] PC_STORE     = 4'd5;
  localparam logic [PC_W-1:0] PC_GROW      = 4'd6;
  localparam logic [PC_W-1:0] PC_REDUCE    = 4'd7;
  localparam logic [PC_W-1:0] PC_SET_CL    = 4'd8;
  localparam logic [PC_W-1:0] PC_DEC       = 4'd9;
  localparam logic [PC_W-1:0] PC_CD_TEST   = 4'd10;
  localparam logic [PC_W-1:0] PC_ADJUST    = 4'd11;
  localparam logic [PC_W-1:0] PC_FIN       = 4'd12;

  typedef struct packed {
    act_t            act;
    cnd_t            cnd;
    logic [PC_W-1:0] target;
    logic            last;
  } uword_t;

  typedef struct packed {
    logic op_restart;
    logic op_conflict;
    logic op_unused;
    logic div_more;
    logic span_lt;
    logic span_open;
    logic cd_nz;
  } stat_t;

  // microprogram; jumps are tested before the step's action lands
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{act: ACT_NOP, cnd: CND_ALWAYS, target: PC_FIN, last: 1'b0};
    unique case (pc)
      PC_ENTRY:     w = '{act: ACT_NOP,      cnd: CND_RESTART,   target: PC_GROW,   last: 1'b0};
      PC_SEL_CONFL: w = '{act: ACT_NOP,      cnd: CND_CONFLICT,  target: PC_DEC,    last: 1'b0};
      PC_SEL_NONE:  w = '{act: ACT_NOP,      cnd: CND_UNUSED,    target: PC_FIN,    last: 1'b0};
      PC_START:     w = '{act: ACT_START,    cnd: CND_NEVER,     target: PC_FIN,    last: 1'b0};
      PC_DIV:       w = '{act: ACT_DIV,      cnd: CND_DIV_MORE,  target: PC_DIV,    last: 1'b0};
      PC_STORE:     w = '{act: ACT_STORE_LL, cnd: CND_ALWAYS,    target: PC_FIN,    last: 1'b0};
      PC_GROW:      w = '{act: ACT_GROW,     cnd: CND_SPAN_LT,   target: PC_GROW,   last: 1'b0};
      PC_REDUCE:    w = '{act: ACT_REDUCE,   cnd: CND_SPAN_OPEN, target: PC_REDUCE, last: 1'b0};
      PC_SET_CL:    w = '{act: ACT_SET_CL,   cnd: CND_ALWAYS,    target: PC_FIN,    last: 1'b0};
      PC_DEC:       w = '{act: ACT_DEC,      cnd: CND_NEVER,     target: PC_FIN,    last: 1'b0};
      PC_CD_TEST:   w = '{act: ACT_NOP,      cnd: CND_CD_NZ,     target: PC_FIN,    last: 1'b0};
      PC_ADJUST:    w = '{act: ACT_ADJUST,   cnd: CND_ALWAYS,    target: PC_DIV,    last: 1'b0};
      PC_FIN:       w = '{act: ACT_NOP,      cnd: CND_OUT_HELD,  target: PC_FIN,    last: 1'b1};
      default:      w = '{act: ACT_NOP,      cnd: CND_ALWAYS,    target: PC_FIN,    last: 1'b0};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/srls_cdiv.sv
module srls_cdiv (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic                     step,
  input  logic                     ten,
  input  logic [srls_pkg::DPAD-1:0] dividend,
  output logic [srls_pkg::DPAD-1:0] quot,
  output logic                     more
);
  import srls_pkg::*;

  // long division by 3 or 10, MSB first, one 16-bit digit per step;
  // {remainder, digit} / d by reciprocal multiply, quotient digit shifts in from the bottom
  logic [DPAD-1:0]       sh;
  logic [DRW-1:0]        rem;
  logic [DCW-1:0]        cnt;
  logic                  ten_r;

  logic [NUMW-1:0]       num;
  logic [RCPW-1:0]       rcp;
  logic [PRODW-1:0]      prod;
  logic [DIGIT_BITS-1:0] qd;
  logic [NUMW-1:0]       back;
  logic [NUMW-1:0]       r;

  assign num  = {rem, sh[DPAD-1 -: DIGIT_BITS]};
  assign rcp  = ten_r ? RCP_TEN : RCP_THREE;
  assign prod = PRODW'(num) * PRODW'(rcp);
  assign qd   = prod[RCP_SHIFT +: DIGIT_BITS];
  // qd*10 or qd*3
  assign back = ten_r ? (NUMW'(qd) << 3) + (NUMW'(qd) << 1)
                      : (NUMW'(qd) << 1) + NUMW'(qd);
  assign r    = num - back;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      sh    <= dividend;
      rem   <= '0;
      cnt   <= DCW'(DIV_STEPS);
      ten_r <= ten;
    end else if (step && cnt != '0) begin
      sh  <= {sh[DPAD-DIGIT_BITS-1:0], qd};
      rem <= r[DRW-1:0];
      cnt <= cnt - DCW'(1);
    end
  end

  assign quot = sh;
  assign more = cnt > DCW'(1);

endmodule

>>> rtl/core/srls_seq.sv
`include "assert_macros.svh"

module srls_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            out_held,
  input  srls_pkg::stat_t stat,
  output srls_pkg::act_t  act,
  output logic            busy,
  output logic            done
);
  import srls_pkg::*;

  logic [PC_W-1:0] pc;
  uword_t          uw;
  logic            take;

  always_comb begin
    uw = ucode(pc);
    unique case (uw.cnd)
      CND_NEVER:     take = 1'b0;
      CND_ALWAYS:    take = 1'b1;
      CND_RESTART:   take = stat.op_restart;
      CND_CONFLICT:  take = stat.op_conflict;
      CND_UNUSED:    take = stat.op_unused;
      CND_DIV_MORE:  take = stat.div_more;
      CND_SPAN_LT:   take = stat.span_lt;
      CND_SPAN_OPEN: take = stat.span_open;
      CND_CD_NZ:     take = stat.cd_nz;
      CND_OUT_HELD:  take = out_held;
      default:       take = 1'b0;
    endcase
  end

  assign act  = busy ? uw.act : ACT_NOP;
  assign done = busy && uw.last && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_ENTRY;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= PC_ENTRY;
    end else if (busy) begin
      if (done) begin
        busy <= 1'b0;
        pc   <= PC_ENTRY;
      end else begin
        pc <= take ? uw.target : pc + PC_W'(1);
      end
    end
  end

  `SRLS_CHK_RST(a_rst_idle, rst |=> !busy, "sequencer busy after reset")
  `SRLS_CHK(a_idle_pc, !busy |-> pc == PC_ENTRY, "idle sequencer away from entry")
  `SRLS_CHK(a_done_free, done |=> !busy && pc == PC_ENTRY, "sequencer did not retire")
  `SRLS_CHK(a_start_busy, start |=> busy, "accepted word did not start program")

endmodule

>>> rtl/core/srls_dp.sv
module srls_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  logic [srls_pkg::OPW-1:0]               op_in,
  input  logic [srls_pkg::RESTART_INDEX_BITS-1:0] idx_in,
  input  logic [srls_pkg::CCW-1:0]               clause_count,
  input  srls_pkg::act_t                         act,
  output srls_pkg::stat_t                        stat,
  output logic [srls_pkg::CLW-1:0]               cl,
  output logic [srls_pkg::LLW-1:0]               ll,
  output logic                                   cl_set,
  output logic                                   ll_set
);
  import srls_pkg::*;

  localparam int RIB = RESTART_INDEX_BITS;
  localparam int FX1 = FIXW + 1;

  logic [FIXW-1:0] learnt;
  logic [FIXW-1:0] interval;
  logic [31:0]     countdown;
  logic [OPW-1:0]  op_r;
  logic [RIB-1:0]  idx;
  logic [SPW-1:0]  span;
  logic [EW-1:0]   e;

  logic [SPW-1:0]  span_n;
  logic [RIB-1:0]  span_nr;
  logic [RIB-1:0]  idx_mod;
  logic [WCW-1:0]  cl_wide;
  logic [CLW-1:0]  cl_next;
  logic [FX1-1:0]  int_sum;
  logic [FIXW-1:0] int_next;
  logic [DPAD-1:0] ll11;
  logic [DPAD-1:0] cc_fix;
  logic [DPAD-1:0] div_in;
  logic [DPAD-1:0] quot;
  logic [FIXW-1:0] q_sat;
  logic            div_load;
  logic            div_step;
  logic            div_ten;
  logic            div_more;

  // Luby reduce: span 2^k-1 -> 2^(k-1)-1; idx < 2*span_n here, so one subtract
  assign span_n  = (span - SPW'(1)) >> 1;
  assign span_nr = span_n[RIB-1:0];
  assign idx_mod = (idx >= span_nr) ? idx - span_nr : idx;

  assign cl_wide = WCW'(BASE_LIMIT) << e;
  assign cl_next = (cl_wide > WCW'(CL_MAX)) ? CL_MAX : cl_wide[CLW-1:0];

  assign int_sum  = FX1'(interval) + FX1'(interval >> 1);
  assign int_next = int_sum[FIXW] ? FIX_MAX : int_sum[FIXW-1:0];

  assign ll11   = (DPAD'(learnt) << 3) + (DPAD'(learnt) << 1) + DPAD'(learnt);
  assign cc_fix = DPAD'({clause_count, {FRAC_BITS{1'b0}}});

  assign div_load = (act == ACT_START) || (act == ACT_ADJUST);
  assign div_ten  = (act == ACT_ADJUST);
  assign div_step = (act == ACT_DIV);
  assign div_in   = div_ten ? ll11 : cc_fix;
  assign q_sat    = (|quot[DPAD-1:FIXW]) ? FIX_MAX : quot[FIXW-1:0];

  srls_cdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .step     (div_step),
    .ten      (div_ten),
    .dividend (div_in),
    .quot     (quot),
    .more     (div_more)
  );

  always_comb begin
    stat.op_restart  = (op_r == OP_RESTART);
    stat.op_conflict = (op_r == OP_CONFLICT);
    stat.op_unused   = (op_r == OP_UNUSED);
    stat.div_more    = div_more;
    stat.span_lt     = span <= SPW'(idx);
    stat.span_open   = (span - SPW'(1) != SPW'(idx)) && (span > SPW'(1));
    stat.cd_nz       = (countdown != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cl        <= CLW'(BASE_LIMIT);
      learnt    <= '0;
      interval  <= INTERVAL_RESET;
      countdown <= 32'(BASE_LIMIT);
      cl_set    <= 1'b0;
      ll_set    <= 1'b0;
      op_r      <= OP_START;
      span      <= SPW'(1);
      e         <= '0;
    end else if (load) begin
      op_r   <= op_in;
      idx    <= idx_in;
      span   <= SPW'(1);
      e      <= '0;
      cl_set <= 1'b0;
      ll_set <= 1'b0;
    end else begin
      unique case (act) inside
        ACT_NOP, ACT_DIV: begin
        end
        ACT_START: begin
          cl        <= CLW'(BASE_LIMIT);
          interval  <= INTERVAL_RESET;
          countdown <= 32'(BASE_LIMIT);
          cl_set    <= 1'b1;
          ll_set    <= 1'b1;
        end
        ACT_STORE_LL: learnt <= q_sat;
        ACT_GROW: begin
          if (stat.span_lt) begin
            span <= {span[SPW-2:0], 1'b1};
            e    <= e + EW'(1);
          end
        end
        ACT_REDUCE: begin
          if (stat.span_open) begin
            span <= span_n;
            idx  <= idx_mod;
            if (e != '0) begin
              e <= e - EW'(1);
            end
          end
        end
        ACT_SET_CL: begin
          cl     <= cl_next;
          cl_set <= 1'b1;
        end
        ACT_DEC: countdown <= countdown - 32'd1;
        ACT_ADJUST: begin
          interval  <= int_next;
          countdown <= int_next[FIXW-1:FRAC_BITS];
          ll_set    <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign ll = learnt[FIXW-1:FRAC_BITS];

endmodule

>>> rtl/core/sat_restart_limit_scheduler_core.sv
// channel  | handshake                       | word
// event    | event_valid / event_ready       | op, restart_index
// result   | result_valid / result_ready     | conflict_limit, learnt_limit, *_set
// config   | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// One event at a time through a microcoded sequencer, one path per op; a conflict runs
//   longer when the countdown hits zero and the interval and learnt limit grow, and a restart
//   runs the grow and reduce iterations of the Luby search.
// The divide-by-3 / divide-by-10 unit takes one 16-bit digit per cycle.
// Reset restores the limits, interval and countdown; no clearing pass.
// event_ready drops while an event runs; a held result only stalls the final step.
module sat_restart_limit_scheduler_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [srls_pkg::APB_AW-1:0]            paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  logic                                   event_valid,
  output logic                                   event_ready,
  input  logic [srls_pkg::OPW-1:0]               op,
  input  logic [srls_pkg::RESTART_INDEX_BITS-1:0] restart_index,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic [srls_pkg::CLW-1:0]               conflict_limit,
  output logic [srls_pkg::LLW-1:0]               learnt_limit,
  output logic                                   conflict_limit_set,
  output logic                                   learnt_limit_set
);
  import srls_pkg::*;

  logic [CCW-1:0] clause_count;
  logic           cfg_wr;
  logic           accept;
  logic           busy;
  logic           done;
  logic           out_held;
  act_t           act;
  stat_t          stat;
  logic [CLW-1:0] cl;
  logic [LLW-1:0] ll;
  logic           cl_set;
  logic           ll_set;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[APB_AW-1:2] == REG_CLAUSE_COUNT) ? clause_count : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clause_count <= '0;
    end else if (cfg_wr && paddr[APB_AW-1:2] == REG_CLAUSE_COUNT) begin
      clause_count <= pwdata;
    end
  end

  assign event_ready = !busy;
  assign accept      = event_valid && event_ready;
  assign out_held    = result_valid && !result_ready;

  srls_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .out_held (out_held),
    .stat     (stat),
    .act      (act),
    .busy     (busy),
    .done     (done)
  );

  srls_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .op_in        (op),
    .idx_in       (restart_index),
    .clause_count (clause_count),
    .act          (act),
    .stat         (stat),
    .cl           (cl),
    .ll           (ll),
    .cl_set       (cl_set),
    .ll_set       (ll_set)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid       <= 1'b1;
      conflict_limit     <= cl;
      learnt_limit       <= ll;
      conflict_limit_set <= cl_set;
      learnt_limit_set   <= ll_set;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

>>> tb/tb_sat_restart_limit_scheduler_core.sv
module tb_sat_restart_limit_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;
  import srls_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 8;
  localparam int PHASE_WORDS    = 235;
  localparam int TAIL_CYCLES    = 60;
  localparam logic [APB_AW-1:0] ADDR_CLAUSE_COUNT = {REG_CLAUSE_COUNT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED     = {~REG_CLAUSE_COUNT, 2'b00};

  typedef struct packed {
    logic [OPW-1:0]                op;
    logic [RESTART_INDEX_BITS-1:0] index;
  } event_word_t;

  typedef struct packed {
    logic [CLW-1:0] conflict_limit;
    logic [LLW-1:0] learnt_limit;
    logic           cl_set;
    logic           ll_set;
  } limits_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [APB_AW-1:0]             paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          event_valid = 1'b0;
  logic                          event_ready;
  logic [OPW-1:0]                op = '0;
  logic [RESTART_INDEX_BITS-1:0] restart_index = '0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  logic [CLW-1:0]                conflict_limit;
  logic [LLW-1:0]                learnt_limit;
  logic                          conflict_limit_set;
  logic                          learnt_limit_set;

  // schedule state as the block should hold it
  logic [CCW-1:0]  sched_clause_count  = '0;
  logic [CLW-1:0]  sched_conflict_limit = CLW'(BASE_LIMIT);
  logic [FIXW-1:0] sched_learnt_fix    = '0;
  logic [FIXW-1:0] sched_interval_fix  = INTERVAL_RESET;
  logic [31:0]     sched_countdown     = 32'(BASE_LIMIT);

  event_word_t pending_events[$];
  limits_t     expected_limits[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned phase_words = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  sat_restart_limit_scheduler_core dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned luby_power(input logic [RESTART_INDEX_BITS-1:0] index);
    logic [31:0] span;
    logic [31:0] pos;
    int unsigned e;
    span = 1;
    pos = 32'(index);
    e = 0;
    // grow a 2^k-1 block until it covers the position, then fold back into it
    while (span < pos + 1) begin
      span = 2 * span + 1;
      e++;
    end
    while (span - 1 != pos && span > 1) begin
      span = (span - 1) >> 1;
      if (e != 0) e--;
      pos = pos % span;
    end
    return e;
  endfunction

  function automatic logic [FIXW-1:0] clamp_fix(input logic [63:0] v);
    return (v > 64'(FIX_MAX)) ? FIX_MAX : v[FIXW-1:0];
  endfunction

  function automatic limits_t predict_limits(input logic [OPW-1:0] kind,
                                             input logic [RESTART_INDEX_BITS-1:0] index);
    limits_t r;
    logic [63:0] wide;
    int unsigned e;
    r.cl_set = 1'b0;
    r.ll_set = 1'b0;
    case (kind)
      OP_START: begin
        sched_conflict_limit = CLW'(BASE_LIMIT);
        sched_learnt_fix = clamp_fix((64'(sched_clause_count) << FRAC_BITS) / 3);
        sched_interval_fix = INTERVAL_RESET;
        sched_countdown = 32'(BASE_LIMIT);
        r.cl_set = 1'b1;
        r.ll_set = 1'b1;
      end
      OP_RESTART: begin
        e = luby_power(index);
        wide = (e >= CLW) ? 64'(CL_MAX) + 1 : 64'(BASE_LIMIT) << e;
        sched_conflict_limit = (wide > 64'(CL_MAX)) ? CL_MAX : wide[CLW-1:0];
        r.cl_set = 1'b1;
      end
      OP_CONFLICT: begin
        sched_countdown = sched_countdown - 1;
        if (sched_countdown == 0) begin
          sched_interval_fix = clamp_fix(64'(sched_interval_fix) + 64'(sched_interval_fix >> 1));
          sched_countdown = sched_interval_fix[FRAC_BITS +: 32];
          sched_learnt_fix = clamp_fix(64'(sched_learnt_fix) * 11 / 10);
          r.ll_set = 1'b1;
        end
      end
      default: ;
    endcase
    r.conflict_limit = sched_conflict_limit;
    r.learnt_limit = sched_learnt_fix[FRAC_BITS +: LLW];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < 30)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[APB_AW-1:2] == REG_CLAUSE_COUNT) sched_clause_count = data;
  endtask

  task automatic queue_event(input logic [OPW-1:0] kind,
                             input logic [RESTART_INDEX_BITS-1:0] index);
    event_word_t w;
    w.op = kind;
    w.index = index;
    pending_events.push_back(w);
    phase_words++;
  endtask

  function automatic logic [RESTART_INDEX_BITS-1:0] rand_index();
    int unsigned k;
    k = $urandom_range(1, RESTART_INDEX_BITS);
    case ($urandom_range(2))
      0: return RESTART_INDEX_BITS'($urandom);
      1: return RESTART_INDEX_BITS'($urandom_range(255));
      default: return RESTART_INDEX_BITS'((64'd1 << k) - 1 - 64'($urandom_range(1)));
    endcase
  endfunction

  // mostly a start followed by a long conflict run with restarts and unused ops mixed in,
  // so the countdown reaches zero; now and then plain noise
  task automatic queue_episode(input int unsigned room);
    int unsigned n;
    int unsigned r;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(5, 30);
      if (n > room) n = room;
      repeat (n) queue_event(OPW'($urandom_range(3)), rand_index());
    end else begin
      if ($urandom_range(3) != 0) queue_event(OP_START, RESTART_INDEX_BITS'($urandom));
      n = $urandom_range(40, 320);
      if (n > room) n = room;
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 88)
          queue_event(OP_CONFLICT, RESTART_INDEX_BITS'($urandom));
        else if (r < 97)
          queue_event(OP_RESTART, rand_index());
        else
          queue_event(OP_UNUSED, RESTART_INDEX_BITS'($urandom));
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_events.size() != 0 || event_valid || expected_limits.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin : event_driver
    event_word_t w;
    if (rst) begin
      event_valid <= 1'b0;
    end else if (!event_valid || event_ready) begin
      if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_events.pop_front();
        event_valid <= 1'b1;
        op <= w.op;
        restart_index <= w.index;
      end else begin
        event_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_monitor
    limits_t got;
    limits_t want;
    if (!rst) begin
      if (event_valid && event_ready)
        expected_limits.push_back(predict_limits(op, restart_index));
      if (result_valid && result_ready) begin
        got = '{conflict_limit, learnt_limit, conflict_limit_set, learnt_limit_set};
        if (expected_limits.size() == 0) begin
          report_mismatch("result word with nothing expected", 64'(got.conflict_limit), 0);
        end else begin
          want = expected_limits.pop_front();
          if (got.conflict_limit != want.conflict_limit)
            report_mismatch("conflict_limit", 64'(got.conflict_limit), 64'(want.conflict_limit));
          if (got.learnt_limit != want.learnt_limit)
            report_mismatch("learnt_limit", 64'(got.learnt_limit), 64'(want.learnt_limit));
          if (got.cl_set != want.cl_set)
            report_mismatch("conflict_limit_set", 64'(got.cl_set), 64'(want.cl_set));
          if (got.ll_set != want.ll_set)
            report_mismatch("learnt_limit_set", 64'(got.ll_set), 64'(want.ll_set));
        end
      end
      if ((event_valid && event_ready) || (result_valid && result_ready) ||
          (psel && penable && pwrite && pready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [RESTART_INDEX_BITS-1:0] corner_idx[12];
    logic [31:0] clause_value;
    corner_idx = '{20'd1, 20'd2, 20'd3, 20'd6, 20'd7, 20'd8, 20'hFFFFE, 20'hFFFFF,
                   20'h7FFFF, 20'h7FFFE, 20'h55555, 20'hAAAAA};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_write(ADDR_CLAUSE_COUNT, 32'hFFFF_FFFF);
    apb_write(ADDR_UNMAPPED, 32'h0000_1234);  // no register there, must not land
    queue_event(OP_CONFLICT, '0);             // before any start: runs on reset values
    queue_event(OP_UNUSED, '1);
    queue_event(OP_RESTART, '0);
    queue_event(OP_START, '1);
    foreach (corner_idx[i]) queue_event(OP_RESTART, corner_idx[i]);
    queue_event(OP_CONFLICT, '1);
    queue_event(OP_UNUSED, '0);
    queue_event(OP_START, '0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      case (p)
        0: clause_value = 32'd0;
        1: clause_value = 32'hFFFF_FFFF;
        2: clause_value = 32'd3;
        4: clause_value = 32'd1;
        5: clause_value = $urandom_range(100000);
        6: clause_value = 32'h8000_0000;
        default: clause_value = $urandom;
      endcase
      apb_write(ADDR_CLAUSE_COUNT, clause_value);
      phase_words = 0;
      while (phase_words < PHASE_WORDS) queue_episode(PHASE_WORDS - phase_words);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
